// File: hw/rtl/linear_gain_ramp_saturate_unit_macros.svh
// assertion helpers shared by the gain ramp rtl
`ifndef LINEAR_GAIN_RAMP_SATURATE_UNIT_MACROS_SVH
`define LINEAR_GAIN_RAMP_SATURATE_UNIT_MACROS_SVH

// same-cycle implication
`define LGRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LGRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lgrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int MAG_W     = 32;
    localparam int Q_FRAC    = 32;
    localparam int ACC_W     = 47;
    localparam int STEP_W    = 34;
    localparam int DIVN_W    = 33;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd4;

    localparam logic [SAMPLE_W-1:0] SAT16_MAX = 32'h0000_7FFF;
    localparam logic [SAMPLE_W-1:0] SAT32_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAT16_MIN = 32'hFFFF_8000;
    localparam logic [SAMPLE_W-1:0] SAT32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       buffer_start;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } t_out_item;

    typedef struct packed {
        logic             wide;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [ACC_W-1:0] acc;
    } t_job;

endpackage

`default_nettype wire

// File: hw/rtl/lgrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linear_gain_ramp_saturate_unit_macros.svh"

module lgrs_div
    import lgrs_pkg::*;
#(
    parameter int DEN_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVN_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic [DIVN_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIVN_W-1:0] r_q, n_q;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_q[DIVN_W-1]};
        fits   = trial >= {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_q   = {r_q[DIVN_W-2:0], fits};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIVN_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

    `LGRS_ASSERT_IMP(a_div_no_restart, i_clk, i_rst_n, r_busy, !i_start,
        "divider restarted while busy")
    `LGRS_ASSERT_IMP(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy,
        "divider done while still busy")

endmodule

`default_nettype wire

// File: hw/rtl/lgrs_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linear_gain_ramp_saturate_unit_macros.svh"

module lgrs_front
    import lgrs_pkg::*;
#(
    parameter int MAX_CHANNELS   = 8,
    parameter int FRAME_BITS     = 16,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int CFG_W          = 17
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_push,
    output t_job                       o_job,
    input  wire logic                  i_full,
    output logic                       o_div_start,
    output logic [DIVN_W-1:0]          o_div_num,
    output logic [FRAME_BITS-1:0]      o_div_den,
    input  wire logic                  i_div_done,
    input  wire logic [DIVN_W-1:0]     i_div_quo
);

    localparam int GW      = GAIN_FRAC_BITS + 1;
    localparam int Q_SHIFT = Q_FRAC - GAIN_FRAC_BITS;
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ECH_W   = 5;

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    logic                     r_state, n_state;
    logic                     r_pend, n_pend;
    logic                     r_neg, n_neg;
    logic [GW-1:0]            r_sg;
    logic [GW-1:0]            r_eg;
    logic                     r_wide;
    logic [3:0]               r_cc;
    logic [FRAME_BITS-1:0]    r_fc;
    logic [FRAME_BITS-1:0]    r_frame, n_frame;
    logic [CH_W-1:0]          r_chan, n_chan;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic signed [STEP_W-1:0] r_step, n_step;

    logic                     in_fire;
    logic                     adv, beg, beg_pend;
    logic [ECH_W-1:0]         eff_ch;
    logic [ECH_W-1:0]         chan_inc;
    logic [FRAME_BITS-1:0]    eff_fr;
    logic [FRAME_BITS-1:0]    frame_inc;
    logic signed [STEP_W-1:0] quo_pos, quo_s, adv_step;
    logic signed [ACC_W+1:0]  acc_sum;
    logic [ACC_W-1:0]         acc_reload;
    logic [GW-1:0]            gain_diff;
    logic [MAG_W-1:0]         mag;
    logic                     neg;
    logic [16:0]              m16;

    // effective channel and frame counts
    always_comb begin
        if (r_cc == 4'd0) begin
            eff_ch = ECH_W'(1);
        end else if (ECH_W'(r_cc) > ECH_W'(MAX_CHANNELS)) begin
            eff_ch = ECH_W'(MAX_CHANNELS);
        end else begin
            eff_ch = ECH_W'(r_cc);
        end
        eff_fr = (r_fc == '0) ? FRAME_BITS'(1) : r_fc;
    end

    assign chan_inc   = ECH_W'(r_chan) + ECH_W'(1);
    assign frame_inc  = r_frame + FRAME_BITS'(1);
    assign acc_reload = ACC_W'(r_sg) << Q_SHIFT;
    assign gain_diff  = (r_eg >= r_sg) ? (r_eg - r_sg) : (r_sg - r_eg);
    assign quo_pos    = $signed({1'b0, i_div_quo});
    assign quo_s      = r_neg ? -quo_pos : quo_pos;
    assign adv_step   = (r_state == ST_RUN) ? r_step : quo_s;
    assign acc_sum    = $signed({2'b00, r_acc}) + (ACC_W + 2)'(adv_step);

    assign o_cfg_ready = (r_state == ST_RUN);
    assign o_in_stall  = (r_state != ST_RUN) || i_full;
    assign in_fire     = i_in_valid && !o_in_stall;

    // sample classification
    always_comb begin
        m16 = 17'h10000 - {1'b0, i_in_item.sample_in[15:0]};
        if (r_wide) begin
            neg = i_in_item.sample_in[SAMPLE_W-1];
            mag = neg ? (MAG_W'(0) - MAG_W'(i_in_item.sample_in))
                      : MAG_W'(i_in_item.sample_in);
        end else begin
            neg = i_in_item.sample_in[15];
            mag = neg ? MAG_W'(m16) : MAG_W'(i_in_item.sample_in[15:0]);
        end
    end

    assign o_push     = in_fire;
    assign o_job.wide = r_wide;
    assign o_job.neg  = neg;
    assign o_job.mag  = mag;
    assign o_job.acc  = i_in_item.buffer_start ? acc_reload : r_acc;

    assign o_div_num = DIVN_W'(gain_diff) << Q_SHIFT;
    assign o_div_den = eff_fr;

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_neg    = r_neg;
        n_frame  = r_frame;
        n_chan   = r_chan;
        n_acc    = r_acc;
        n_step   = r_step;
        adv      = 1'b0;
        beg      = 1'b0;
        beg_pend = 1'b0;
        if (r_state == ST_RUN) begin
            if (in_fire) begin
                if (i_in_item.buffer_start) begin
                    beg      = 1'b1;
                    beg_pend = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
        end else if (i_div_done) begin
            n_step  = quo_s;
            n_state = ST_RUN;
            n_pend  = 1'b0;
            adv     = r_pend;
        end
        if (adv) begin
            if (chan_inc >= eff_ch) begin
                n_chan  = '0;
                n_frame = frame_inc;
                if (acc_sum[ACC_W+1]) begin
                    n_acc = '0;
                end else if (acc_sum[ACC_W]) begin
                    n_acc = ACC_MAX;
                end else begin
                    n_acc = acc_sum[ACC_W-1:0];
                end
                if (frame_inc >= eff_fr) begin
                    beg = 1'b1;
                end
            end else begin
                n_chan = CH_W'(chan_inc);
            end
        end
        if (beg) begin
            n_acc   = acc_reload;
            n_frame = '0;
            n_chan  = '0;
            n_state = ST_DIV;
            n_pend  = beg_pend;
            n_neg   = r_eg < r_sg;
        end
    end

    assign o_div_start = beg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_pend  <= 1'b0;
            r_neg   <= 1'b0;
            r_sg    <= GW'(1) << GAIN_FRAC_BITS;
            r_eg    <= GW'(1) << GAIN_FRAC_BITS;
            r_wide  <= 1'b0;
            r_cc    <= 4'd2;
            r_fc    <= FRAME_BITS'(1024);
            r_frame <= '0;
            r_chan  <= '0;
            r_acc   <= ACC_W'(1) << Q_FRAC;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_neg   <= n_neg;
            r_frame <= n_frame;
            r_chan  <= n_chan;
            r_acc   <= n_acc;
            r_step  <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_START_GAIN:    r_sg   <= i_cfg_data[GW-1:0];
                    CFG_END_GAIN:      r_eg   <= i_cfg_data[GW-1:0];
                    CFG_SAMPLE_WIDTH:  r_wide <= i_cfg_data[0];
                    CFG_CHANNEL_COUNT: r_cc   <= i_cfg_data[3:0];
                    CFG_FRAME_COUNT:   r_fc   <= i_cfg_data[FRAME_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `LGRS_ASSERT_IMP(a_div_idx_clear, i_clk, i_rst_n, r_state == ST_DIV,
        (r_frame == '0) && (r_chan == '0), "indexes not cleared during step division")
    `LGRS_ASSERT_IMP(a_done_expected, i_clk, i_rst_n, i_div_done, r_state == ST_DIV,
        "step quotient arrived while not waiting")

endmodule

`default_nettype wire

// File: hw/rtl/lgrs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linear_gain_ramp_saturate_unit_macros.svh"

module lgrs_fifo
    import lgrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_PTR_W:0]   r_cnt;
    logic               pop;

    assign o_full  = r_cnt == (Q_PTR_W + 1)'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + (Q_PTR_W + 1)'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - (Q_PTR_W + 1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `LGRS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full,
        "request queue written while full")

endmodule

`default_nettype wire

// File: hw/rtl/lgrs_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linear_gain_ramp_saturate_unit_macros.svh"

module lgrs_back
    import lgrs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_item o_out_item
);

    localparam int HI_W   = ACC_W - Q_FRAC;
    localparam int PHI_W  = MAG_W + HI_W;
    localparam int PROD_W = PHI_W + 1;

    logic                    r_s1_v;
    logic                    r_s1_neg;
    logic                    r_s1_wide;
    logic [PHI_W-1:0]        r_hi;
    logic [MAG_W-1:0]        r_lo;
    logic                    r_out_v;
    t_out_item               r_out;

    logic                    out_move;
    logic                    s1_ready;
    logic [MAG_W+Q_FRAC-1:0] lo_full;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       limit;
    logic [PROD_W-1:0]       sat;
    logic                    clip;

    assign out_move = !r_out_v || !i_out_stall;
    assign s1_ready = !r_s1_v || out_move;
    assign o_pop    = i_valid && s1_ready;
    assign lo_full  = i_job.mag * i_job.acc[Q_FRAC-1:0];

    // second stage: sum of partial products and saturation
    always_comb begin
        prod  = PROD_W'(r_hi) + PROD_W'(r_lo);
        limit = r_s1_wide ? PROD_W'(SAT32_MAX) : PROD_W'(SAT16_MAX);
        if (r_s1_neg) begin
            clip = prod > (limit + PROD_W'(1));
            sat  = clip ? (limit + PROD_W'(1)) : prod;
        end else begin
            clip = prod > limit;
            sat  = clip ? limit : prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= o_pop;
            end
            if (out_move) begin
                r_out_v <= r_s1_v;
            end
        end
        if (o_pop) begin
            r_s1_neg  <= i_job.neg;
            r_s1_wide <= i_job.wide;
            r_hi      <= i_job.mag * i_job.acc[ACC_W-1:Q_FRAC];
            r_lo      <= lo_full[MAG_W+Q_FRAC-1:Q_FRAC];
        end
        if (out_move && r_s1_v) begin
            r_out.sample_out <= r_s1_neg ? $signed(SAMPLE_W'(0) - SAMPLE_W'(sat))
                                         : $signed(SAMPLE_W'(sat));
            r_out.clipped    <= clip;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    `LGRS_ASSERT_IMP(a_clip_at_limit, i_clk, i_rst_n, r_out_v && r_out.clipped,
        (r_out.sample_out == SAT32_MAX) || (r_out.sample_out == SAT32_MIN) ||
        (r_out.sample_out == SAT16_MAX) || (r_out.sample_out == SAT16_MIN),
        "clipped result not at a saturation limit")

endmodule

`default_nettype wire

// File: hw/rtl/linear_gain_ramp_saturate_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Linear gain ramp with saturation for interleaved signed PCM. Within a buffer
// one sample is taken per clock unless stalled; every frame's channels share one
// gain that moves by a fixed step per frame from start_gain toward end_gain. A
// sample with buffer_start, and the buffer that starts by itself after the last
// frame, first run the per-frame step through a 33-step restoring divider: such a
// buffer start holds off the next sample until the quotient is back, with a second
// division when the same sample also closes a one-frame buffer, and configuration
// writes are not taken meanwhile. A result is offered through a four-deep request
// queue, a multiply stage and a saturating output register; a stalled output holds
// off input only once the queue and both stages are full. Gains take effect at the
// next buffer start; sample width, channel and frame counts at once.
module linear_gain_ramp_saturate_unit
    import lgrs_pkg::*;
#(
    parameter int MAX_CHANNELS   = 8,
    parameter int FRAME_BITS     = 16,
    parameter int GAIN_FRAC_BITS = 16,
    localparam int CFG_W = (GAIN_FRAC_BITS + 1 > FRAME_BITS) ? GAIN_FRAC_BITS + 1 : FRAME_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item
);

    logic                  push;
    logic                  full;
    logic                  q_valid;
    logic                  pop;
    t_job                  push_job;
    t_job                  pop_job;
    logic                  div_start;
    logic [DIVN_W-1:0]     div_num;
    logic [FRAME_BITS-1:0] div_den;
    logic                  div_done;
    logic [DIVN_W-1:0]     div_quo;

    lgrs_front #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .FRAME_BITS     (FRAME_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .CFG_W          (CFG_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full),
        .o_div_start (div_start),
        .o_div_num   (div_num),
        .o_div_den   (div_den),
        .i_div_done  (div_done),
        .i_div_quo   (div_quo)
    );

    lgrs_div #(
        .DEN_W (FRAME_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    lgrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    lgrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
